// ===== hdl/lct_pkg.sv =====
// ----------------------------------------------------------------------------
// lct_pkg
// Shared types and constants for the key-value cache with LRU replacement
// and per-entry expiry.
// ----------------------------------------------------------------------------
package lct_pkg;

	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int TTL_W   = 16;
	localparam int TIME_W  = 32;
	localparam int CAP_W   = 5;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 2;

	// Operation codes carried in the action field.
	typedef enum logic [1:0] {
		ACT_GET  = 2'd0,
		ACT_PUT  = 2'd1,
		ACT_FILL = 2'd2,
		ACT_TICK = 2'd3
	} action_t;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_TTL = 2'd1;

	localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;
	localparam logic [TTL_W-1:0] DEFAULT_TTL_RESET = 16'd0;

	// Read value reported when a get does not hit.
	localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

	// Lookup status handed from the match unit to the update logic.
	typedef struct packed {
		logic hit;    // a valid entry holds the key
		logic stale;  // that entry is past its expiry time
	} match_stat_t;

endpackage

// ===== hdl/lct_if.sv =====
// ----------------------------------------------------------------------------
// lct_if
// Request and response channels of the cache, each with valid/ready flow
// control.
// ----------------------------------------------------------------------------
interface lct_req_if;
	logic                               valid;
	logic                               ready;
	logic [1:0]                         action;
	logic signed [lct_pkg::KEY_W-1:0]   key;
	logic signed [lct_pkg::VAL_W-1:0]   value;
	logic [lct_pkg::TTL_W-1:0]          ttl;

	modport source (output valid, action, key, value, ttl, input ready);
	modport sink (input valid, action, key, value, ttl, output ready);
endinterface

interface lct_rsp_if;
	logic                               valid;
	logic                               ready;
	logic                               hit;
	logic signed [lct_pkg::VAL_W-1:0]   read_value;
	logic                               expired;
	logic                               fetch_request;
	logic                               write_through;
	logic                               evicted;
	logic signed [lct_pkg::KEY_W-1:0]   evicted_key;

	modport source (output valid, hit, read_value, expired, fetch_request,
		write_through, evicted, evicted_key, input ready);
	modport sink (input valid, hit, read_value, expired, fetch_request,
		write_through, evicted, evicted_key, output ready);
endinterface

// ===== hdl/lct_match.sv =====
// ----------------------------------------------------------------------------
// lct_match
// Parallel key compare across all entries, with the matched entry's value,
// rank and expiry check.
// ----------------------------------------------------------------------------
module lct_match #(
	parameter int ENTRIES = 16,
	parameter int RW = 4
) (
	input  logic [ENTRIES-1:0]                ent_valid,
	input  logic signed [lct_pkg::KEY_W-1:0]  ent_key [ENTRIES],
	input  logic signed [lct_pkg::VAL_W-1:0]  ent_value [ENTRIES],
	input  logic [lct_pkg::TIME_W-1:0]        ent_expiry [ENTRIES],
	input  logic [RW-1:0]                     rank [ENTRIES],
	input  logic signed [lct_pkg::KEY_W-1:0]  lookup_key,
	input  logic [lct_pkg::TIME_W-1:0]        now,
	output logic [ENTRIES-1:0]                match_oh,
	output lct_pkg::match_stat_t              stat,
	output logic signed [lct_pkg::VAL_W-1:0]  m_value,
	output logic [RW-1:0]                     m_rank
);

	logic [lct_pkg::TIME_W-1:0] m_expiry;

	// Keys are unique among valid entries, so at most one bit is set and an
	// AND-OR select picks the matched fields.
	always_comb begin
		m_value  = '0;
		m_rank   = '0;
		m_expiry = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match_oh[i] = ent_valid[i] && (ent_key[i] == lookup_key);
			m_value  = m_value  | ({lct_pkg::VAL_W{match_oh[i]}} & ent_value[i]);
			m_rank   = m_rank   | ({RW{match_oh[i]}} & rank[i]);
			m_expiry = m_expiry | ({lct_pkg::TIME_W{match_oh[i]}} & ent_expiry[i]);
		end
	end

	assign stat.hit   = |match_oh;
	assign stat.stale = now > m_expiry;

endmodule

// ===== hdl/lru_cache_with_ttl.sv =====
// ----------------------------------------------------------------------------
// lru_cache_with_ttl
// Fully associative key-value cache with least-recently-used replacement and
// per-entry expiry counted in one-second ticks.
// ----------------------------------------------------------------------------
// Flow: an accepted request sits in the request register; one combinational
// pass of lookup and entry-register update leads to the response register,
// which hands the response over. Throughput: one request per cycle while the
// response is not stalled.
// Reset: entry valid bits, recency ranks, the clock and the entry count clear
// at once; capacity returns to 16 and default_ttl to 0. No clearing pass.
// ----------------------------------------------------------------------------
module lru_cache_with_ttl #(
	parameter int ENTRIES = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [lct_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [lct_pkg::CFG_W-1:0]              cfg_wdata,
	lct_req_if.sink                                req,
	lct_rsp_if.source                              rsp
);

	// Rank width holds ranks 0..ENTRIES-1, count width holds 0..ENTRIES.
	localparam int RW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	// Configuration registers.
	logic [lct_pkg::CAP_W-1:0] cap_q;
	logic [lct_pkg::TTL_W-1:0] dttl_q;

	// Request register. The single processing pass works on this stage.
	logic                               valid_s1;
	lct_pkg::action_t                   action_s1;
	logic signed [lct_pkg::KEY_W-1:0]   key_s1;
	logic signed [lct_pkg::VAL_W-1:0]   value_s1;
	logic [lct_pkg::TTL_W-1:0]          ttl_s1;

	// Entry storage. Valid bits and ranks are control state and reset; keys,
	// values and expiry times are only read behind a valid bit.
	logic [ENTRIES-1:0]                 ent_valid_q;
	logic signed [lct_pkg::KEY_W-1:0]   ent_key_q [ENTRIES];
	logic signed [lct_pkg::VAL_W-1:0]   ent_value_q [ENTRIES];
	logic [lct_pkg::TIME_W-1:0]         ent_expiry_q [ENTRIES];
	logic [RW-1:0]                      rank_q [ENTRIES];
	logic [lct_pkg::TIME_W-1:0]         now_q;
	logic [CW-1:0]                      count_q;

	// Response register.
	logic                               rsp_valid_q;
	logic                               hit_q;
	logic signed [lct_pkg::VAL_W-1:0]   read_value_q;
	logic                               expired_q;
	logic                               fetch_q;
	logic                               wthru_q;
	logic                               evicted_q;
	logic signed [lct_pkg::KEY_W-1:0]   ev_key_q;

	// Lookup results.
	logic [ENTRIES-1:0]                 match_oh;
	lct_pkg::match_stat_t               mstat;
	logic signed [lct_pkg::VAL_W-1:0]   m_value;
	logic [RW-1:0]                      m_rank;

	// Update pass.
	logic                               advance;
	logic                               is_get;
	logic                               is_ins;
	logic                               remove_en;
	logic                               promote_en;
	logic                               do_ev;
	logic [CW-1:0]                      eff_cap;
	logic [ENTRIES-1:0]                 v1;
	logic [RW-1:0]                      r1 [ENTRIES];
	logic [CW-1:0]                      c1;
	logic [ENTRIES-1:0]                 lru_oh;
	logic [ENTRIES-1:0]                 v2;
	logic [CW-1:0]                      c2;
	logic [ENTRIES-1:0]                 free_vec;
	logic [ENTRIES-1:0]                 slot_oh;
	logic signed [lct_pkg::KEY_W-1:0]   ev_key;
	logic [lct_pkg::TTL_W-1:0]          life;
	logic [lct_pkg::TIME_W:0]           exp_sum;
	logic [lct_pkg::TIME_W-1:0]         exp_new;
	logic [ENTRIES-1:0]                 nxt_valid;
	logic [RW-1:0]                      nxt_rank [ENTRIES];
	logic [CW-1:0]                      nxt_count;
	logic [lct_pkg::TIME_W-1:0]         nxt_now;

	// ------------------------------------------------------------------------
	// Handshake. The request register moves into the response register when
	// the response register is empty or being emptied in the same cycle, so a
	// new request can be taken while a finished response waits.
	// ------------------------------------------------------------------------
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	// ------------------------------------------------------------------------
	// Configuration writes. Indexes beyond the register list are dropped.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= lct_pkg::CAPACITY_RESET;
			dttl_q <= lct_pkg::DEFAULT_TTL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lct_pkg::REG_CAPACITY:    cap_q  <= cfg_wdata[lct_pkg::CAP_W-1:0];
				lct_pkg::REG_DEFAULT_TTL: dttl_q <= cfg_wdata[lct_pkg::TTL_W-1:0];
				default: ;
			endcase
		end
	end

	// A capacity of zero behaves as one, and a capacity above the entry count
	// of the array behaves as the full array.
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CW'(1);
		end else if (int'(cap_q) > ENTRIES) begin
			eff_cap = CW'(ENTRIES);
		end else begin
			eff_cap = CW'(cap_q);
		end
	end

	// ------------------------------------------------------------------------
	// Request register.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			action_s1 <= lct_pkg::action_t'(req.action);
			key_s1    <= req.key;
			value_s1  <= req.value;
			ttl_s1    <= req.ttl;
		end
	end

	// ------------------------------------------------------------------------
	// Parallel lookup of the key held in the request register.
	// ------------------------------------------------------------------------
	lct_match #(
		.ENTRIES (ENTRIES),
		.RW      (RW)
	) u_match (
		.ent_valid  (ent_valid_q),
		.ent_key    (ent_key_q),
		.ent_value  (ent_value_q),
		.ent_expiry (ent_expiry_q),
		.rank       (rank_q),
		.lookup_key (key_s1),
		.now        (now_q),
		.match_oh   (match_oh),
		.stat       (mstat),
		.m_value    (m_value),
		.m_rank     (m_rank)
	);

	assign is_get = (action_s1 == lct_pkg::ACT_GET);
	assign is_ins = (action_s1 == lct_pkg::ACT_PUT) || (action_s1 == lct_pkg::ACT_FILL);

	// A live get hit promotes the entry. An expired get hit, and a put or fill
	// that finds its own key, removes the matched entry first.
	assign promote_en = is_get && mstat.hit && !mstat.stale;
	assign remove_en  = mstat.hit && (is_ins || (is_get && mstat.stale));

	// ------------------------------------------------------------------------
	// Recency ranks. Valid entries always hold the distinct ranks
	// 0..count-1, rank 0 being the most recent, so the least recent entry is
	// the one whose rank equals count-1.
	// ------------------------------------------------------------------------
	always_comb begin
		// Step one: take out the matched entry, closing the gap above it.
		v1 = ent_valid_q;
		c1 = count_q;
		for (int i = 0; i < ENTRIES; i++) begin
			r1[i] = rank_q[i];
			if (remove_en && ent_valid_q[i] && (rank_q[i] > m_rank)) begin
				r1[i] = rank_q[i] - RW'(1);
			end
		end
		if (remove_en) begin
			v1 = ent_valid_q & ~match_oh;
			c1 = count_q - CW'(1);
		end

		// Step two: when full, drop the least recent entry. It holds the top
		// rank, so no other rank moves.
		ev_key = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			lru_oh[i] = v1[i] && (r1[i] == RW'(c1 - CW'(1)));
			ev_key = ev_key | ({lct_pkg::KEY_W{lru_oh[i]}} & ent_key_q[i]);
		end
		do_ev = is_ins && (c1 >= eff_cap) && (|lru_oh);
		v2 = do_ev ? (v1 & ~lru_oh) : v1;
		c2 = do_ev ? (c1 - CW'(1)) : c1;

		// Step three: the lowest free slot takes the new entry.
		free_vec = ~v2;
		slot_oh  = is_ins ? (free_vec & (~free_vec + ENTRIES'(1))) : '0;

		// Next state of valid bits, ranks and count.
		nxt_valid = v1;
		nxt_count = c1;
		for (int i = 0; i < ENTRIES; i++) begin
			nxt_rank[i] = r1[i];
		end
		if (promote_en) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (match_oh[i]) begin
					nxt_rank[i] = '0;
				end else if (ent_valid_q[i] && (rank_q[i] < m_rank)) begin
					nxt_rank[i] = rank_q[i] + RW'(1);
				end else begin
					nxt_rank[i] = rank_q[i];
				end
			end
		end else if (is_ins) begin
			nxt_valid = v2 | slot_oh;
			nxt_count = (|slot_oh) ? (c2 + CW'(1)) : c2;
			for (int i = 0; i < ENTRIES; i++) begin
				if (slot_oh[i]) begin
					nxt_rank[i] = '0;
				end else if (v2[i] && (|slot_oh)) begin
					nxt_rank[i] = r1[i] + RW'(1);
				end else begin
					nxt_rank[i] = r1[i];
				end
			end
		end
	end

	// Expiry of a new entry is the current time plus its lifetime, held at
	// the top of the range when the sum overflows.
	assign life    = (action_s1 == lct_pkg::ACT_PUT) ? ttl_s1 : dttl_q;
	assign exp_sum = {1'b0, now_q} + (lct_pkg::TIME_W + 1)'(life);
	assign exp_new = exp_sum[lct_pkg::TIME_W] ? '1 : exp_sum[lct_pkg::TIME_W-1:0];

	// The time counter stops at its maximum.
	assign nxt_now = ((action_s1 == lct_pkg::ACT_TICK) && (now_q != '1)) ?
		(now_q + lct_pkg::TIME_W'(1)) : now_q;

	// ------------------------------------------------------------------------
	// State update, once per request leaving the request register.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= '0;
			now_q       <= '0;
			count_q     <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (advance) begin
			ent_valid_q <= nxt_valid;
			now_q       <= nxt_now;
			count_q     <= nxt_count;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= nxt_rank[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (advance && slot_oh[i]) begin
				ent_key_q[i]    <= key_s1;
				ent_value_q[i]  <= value_s1;
				ent_expiry_q[i] <= exp_new;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Response register. Every request produces exactly one transaction.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= advance || (rsp_valid_q && !rsp.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_q        <= promote_en;
			read_value_q <= promote_en ? m_value : lct_pkg::MISS_VALUE;
			expired_q    <= is_get && mstat.hit && mstat.stale;
			fetch_q      <= is_get && !promote_en;
			wthru_q      <= (action_s1 == lct_pkg::ACT_PUT);
			evicted_q    <= do_ev;
			ev_key_q     <= do_ev ? ev_key : '0;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.hit           = hit_q;
	assign rsp.read_value    = read_value_q;
	assign rsp.expired       = expired_q;
	assign rsp.fetch_request = fetch_q;
	assign rsp.write_through = wthru_q;
	assign rsp.evicted       = evicted_q;
	assign rsp.evicted_key   = ev_key_q;

endmodule

// ===== hdl/lct_checker.sv =====
// ----------------------------------------------------------------------------
// lct_port_checks
// Port-level checks on the cache response channel.
// ----------------------------------------------------------------------------
module lct_port_checks (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               rsp_valid,
	input logic                               rsp_ready,
	input logic                               rsp_hit,
	input logic signed [lct_pkg::VAL_W-1:0]   rsp_read_value,
	input logic                               rsp_expired,
	input logic                               rsp_fetch,
	input logic                               rsp_wthru,
	input logic                               rsp_evicted,
	input logic signed [lct_pkg::KEY_W-1:0]   rsp_evicted_key
);

	// A stalled response keeps its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) &&
		$stable(rsp_read_value) && $stable(rsp_evicted_key))
		else $error("response changed while stalled");

	// A hit never also reports a miss, an expiry, an eviction or a write.
	a_hit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_hit |-> !rsp_fetch && !rsp_expired && !rsp_evicted && !rsp_wthru)
		else $error("hit combined with another outcome");

	// Without a hit the read value is all ones.
	a_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_hit |-> rsp_read_value == lct_pkg::MISS_VALUE)
		else $error("read value set without a hit");

	// An expired entry always leads to a fetch request.
	a_expired_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_expired |-> rsp_fetch)
		else $error("expired without fetch request");

	// The evicted key is zero unless an eviction took place.
	a_ev_key: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_evicted |-> rsp_evicted_key == '0)
		else $error("evicted key set without eviction");

endmodule

bind lru_cache_with_ttl lct_port_checks u_lct_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_hit         (rsp.hit),
	.rsp_read_value  (rsp.read_value),
	.rsp_expired     (rsp.expired),
	.rsp_fetch       (rsp.fetch_request),
	.rsp_wthru       (rsp.write_through),
	.rsp_evicted     (rsp.evicted),
	.rsp_evicted_key (rsp.evicted_key)
);

// ===== tb/lct_checker.sv =====
// ----------------------------------------------------------------------------
// lct_checker
// Watches the request, response and configuration ports of the cache, keeps
// a shadow copy of the cache contents, and compares every response with the
// one predicted for the request that caused it.
// ----------------------------------------------------------------------------
module lct_checker import lct_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	lct_req_if                   req,
	lct_rsp_if                   rsp,
	output int                   mismatches,
	output int                   outstanding,
	output int                   hits_seen,
	output int                   expired_seen,
	output int                   evictions_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] read_value;
		logic             expired;
		logic             fetch_request;
		logic             write_through;
		logic             evicted;
		logic [KEY_W-1:0] evicted_key;
	} cache_rsp_t;

	// Shadow copy of the cache. Age 0 is the most recently used valid entry.
	logic              slot_used   [ENTRIES];
	logic [KEY_W-1:0]  slot_key    [ENTRIES];
	logic [VAL_W-1:0]  slot_value  [ENTRIES];
	logic [TIME_W-1:0] slot_expiry [ENTRIES];
	int unsigned       slot_age    [ENTRIES];
	logic [TIME_W-1:0] now_s;
	int unsigned       used_count;
	logic [CAP_W-1:0]  capacity_reg;
	logic [TTL_W-1:0]  fill_ttl_reg;

	cache_rsp_t rsp_expect_q[$];
	int fail_total  = 0;
	int rsp_total   = 0;
	int queue_depth = 0;
	int hit_total   = 0;
	int stale_total = 0;
	int evict_total = 0;

	assign mismatches     = fail_total;
	assign outstanding    = queue_depth;
	assign hits_seen      = hit_total;
	assign expired_seen   = stale_total;
	assign evictions_seen = evict_total;

	function automatic int lookup_slot(logic [KEY_W-1:0] k);
		for (int i = 0; i < ENTRIES; i++)
			if (slot_used[i] && slot_key[i] == k)
				return i;
		return -1;
	endfunction

	function automatic void drop_slot(int s);
		int unsigned r = slot_age[s];
		for (int i = 0; i < ENTRIES; i++)
			if (slot_used[i] && slot_age[i] > r)
				slot_age[i]--;
		slot_used[s] = 1'b0;
		slot_age[s] = 0;
		if (used_count > 0)
			used_count--;
	endfunction

	// Put and fill: replace a same-key entry silently, evict the least recent
	// entry when full (expiry plays no part), insert as most recent.
	function automatic void store_entry(logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
			logic [TTL_W-1:0] life, inout cache_rsp_t r);
		int s;
		int unsigned cap_eff;
		logic [TIME_W:0] sum;
		s = lookup_slot(k);
		if (s >= 0)
			drop_slot(s);
		cap_eff = (capacity_reg == 0) ? 1 : (capacity_reg > ENTRIES) ? ENTRIES : capacity_reg;
		if (used_count >= cap_eff) begin
			s = -1;
			for (int i = 0; i < ENTRIES; i++)
				if (slot_used[i] && (s < 0 || slot_age[i] > slot_age[s]))
					s = i;
			if (s >= 0) begin
				r.evicted = 1'b1;
				r.evicted_key = slot_key[s];
				drop_slot(s);
			end
		end
		s = -1;
		for (int i = ENTRIES - 1; i >= 0; i--)
			if (!slot_used[i])
				s = i;
		if (s < 0)
			return;
		for (int i = 0; i < ENTRIES; i++)
			if (slot_used[i])
				slot_age[i]++;
		sum = {1'b0, now_s} + life;
		slot_used[s] = 1'b1;
		slot_key[s] = k;
		slot_value[s] = v;
		slot_expiry[s] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
		slot_age[s] = 0;
		used_count++;
	endfunction

	function automatic cache_rsp_t predict_response(logic [1:0] act, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] v, logic [TTL_W-1:0] t);
		cache_rsp_t r;
		int s;
		int unsigned rank;
		r = '0;
		r.read_value = MISS_VALUE;
		case (action_t'(act))
			ACT_GET: begin
				s = lookup_slot(k);
				if (s < 0) begin
					r.fetch_request = 1'b1;
				end else if (now_s > slot_expiry[s]) begin
					drop_slot(s);
					r.expired = 1'b1;
					r.fetch_request = 1'b1;
				end else begin
					r.hit = 1'b1;
					r.read_value = slot_value[s];
					rank = slot_age[s];
					for (int i = 0; i < ENTRIES; i++)
						if (slot_used[i] && slot_age[i] < rank)
							slot_age[i]++;
					slot_age[s] = 0;
				end
			end
			ACT_PUT: begin
				r.write_through = 1'b1;
				store_entry(k, v, t, r);
			end
			ACT_FILL: begin
				store_entry(k, v, fill_ttl_reg, r);
			end
			default: begin
				if (now_s != '1)
					now_s++;
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		fail_total++;
		if (fail_total <= 25)
			$display("ERROR at %0t: %s", $realtime, msg);
	endtask

	task automatic check_field(string name, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("response %0d, %s is %h, expected %h",
				rsp_total, name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		cache_rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				slot_used[i] = 1'b0;
				slot_age[i] = 0;
			end
			now_s = '0;
			used_count = 0;
			capacity_reg = CAPACITY_RESET;
			fill_ttl_reg = DEFAULT_TTL_RESET;
			rsp_expect_q.delete();
			queue_depth = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				rsp_total++;
				if (rsp_expect_q.size() == 0) begin
					report_mismatch($sformatf("response %0d arrived with no request pending",
						rsp_total));
				end else begin
					want = rsp_expect_q.pop_front();
					check_field("hit", rsp.hit, want.hit);
					check_field("read_value", rsp.read_value, want.read_value);
					check_field("expired", rsp.expired, want.expired);
					check_field("fetch_request", rsp.fetch_request, want.fetch_request);
					check_field("write_through", rsp.write_through, want.write_through);
					check_field("evicted", rsp.evicted, want.evicted);
					check_field("evicted_key", rsp.evicted_key, want.evicted_key);
					hit_total += want.hit;
					stale_total += want.expired;
					evict_total += want.evicted;
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_CAPACITY)
					capacity_reg = cfg_wdata[CAP_W-1:0];
				else if (cfg_index == REG_DEFAULT_TTL)
					fill_ttl_reg = cfg_wdata[TTL_W-1:0];
			end
			if (req.valid && req.ready)
				rsp_expect_q.push_back(predict_response(req.action, req.key, req.value,
					req.ttl));
			queue_depth = rsp_expect_q.size();
		end
	end

endmodule

// ===== tb/tb_lru_cache_with_ttl.sv =====
// ----------------------------------------------------------------------------
// tb_lru_cache_with_ttl
// Drives the cache with a directed opening and then random get, put, fill and
// tick traffic over several capacity and default lifetime settings, with
// random flow-control gaps on both channels; a checker judges each response.
// ----------------------------------------------------------------------------
module tb_lru_cache_with_ttl;
	timeunit 1ns;
	timeprecision 1ps;
	import lct_pkg::*;

	// The watchdog allows far more than the slowest legal run needs, which has
	// under 900 transactions even with the heaviest stalls.
	localparam int LIMIT_CYCLES = 200000;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 100;
	localparam int POOL_MAX     = 24;

	// Indexes past the two real registers; writes to them must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	// Per-phase settings. Capacity 0 acts as 1 and anything above 16 as 16;
	// default lifetimes cover both extremes and short values that expire.
	localparam int CAP_TAB [PHASES] = '{16, 1, 0, 4, 31, 17, 8, 2};
	localparam int TTL_TAB [PHASES] = '{0, 5, 65535, 2, 3, 0, 1, 65535};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	lct_req_if req_ch();
	lct_rsp_if rsp_ch();

	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int items_sent   = 0;
	int fail_count;
	int pending;
	int hit_count;
	int expired_count;
	int evict_count;

	logic [KEY_W-1:0] key_pool [POOL_MAX];
	int pool_size;

	lru_cache_with_ttl #(
		.ENTRIES(16)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	lct_checker #(
		.ENTRIES(16)
	) i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.req            (req_ch),
		.rsp            (rsp_ch),
		.mismatches     (fail_count),
		.outstanding    (pending),
		.hits_seen      (hit_count),
		.expired_seen   (expired_count),
		.evictions_seen (evict_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// The response side stalls on its own, one random decision per cycle, so
	// stalls land on every point of the request and response timing.
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
		end
	end

	// Watchdog: a hung handshake or a lost response ends the run here.
	initial begin
		for (int cycles = 0; cycles < LIMIT_CYCLES; cycles++)
			@(posedge clk);
		$display("ERROR: cycle limit of %0d reached", LIMIT_CYCLES);
		$display("simulation failed");
		$finish;
	end

	// One register write. The enable drops for a cycle afterwards so that
	// back-to-back writes never schedule two values on it in one time step.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Presents one transaction and returns at the edge that accepts it. Valid
	// stays high on return so the next transaction can follow without a gap;
	// a random idle stretch first lowers it in a step of its own.
	task automatic send_req(action_t act, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
			logic [TTL_W-1:0] t);
		if ($urandom_range(0, 99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
		end
		req_ch.valid  <= 1'b1;
		req_ch.action <= act;
		req_ch.key    <= k;
		req_ch.value  <= v;
		req_ch.ttl    <= t;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
	endtask

	// Holds the request side quiet until every predicted response has been
	// checked; configuration writes are only made after this. The wait begins
	// with a clock edge, so the last accepted transaction is already counted.
	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		logic [CFG_W-1:0] wd;
		logic [KEY_W-1:0] k;
		logic [TTL_W-1:0] t;
		action_t act;
		int pick;

		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= REG_CAPACITY;
		cfg_wdata     <= '0;
		req_ch.valid  <= 1'b0;
		req_ch.action <= ACT_GET;
		req_ch.key    <= '0;
		req_ch.value  <= '0;
		req_ch.ttl    <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening with the reset settings: capacity 16, fill
		// lifetime 0. The sender is mostly busy and the receiver mostly idle.
		src_idle_pct = 23;
		snk_idle_pct = 61;
		// A get on an empty cache misses and asks for a fetch.
		send_req(ACT_GET, 32'h8000_0000, 32'h0, 16'h0);
		// Most negative key, most positive value, zero lifetime.
		send_req(ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0000);
		// Still live at its expiry second, since only later is expired.
		send_req(ACT_GET, 32'h8000_0000, 32'h0, 16'h0);
		// A tick with every other field set to all ones.
		send_req(ACT_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		// Now past expiry: removed and reported expired, then a plain miss.
		send_req(ACT_GET, 32'h8000_0000, 32'h0, 16'h0);
		send_req(ACT_GET, 32'h8000_0000, 32'h0, 16'h0);
		// Most positive key with the longest lifetime, then put again under
		// the same key: a silent replacement, not an eviction.
		send_req(ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
		send_req(ACT_PUT, 32'h7FFF_FFFF, 32'h0000_0000, 16'hFFFF);
		// A fill carries no write-through and takes the default lifetime.
		send_req(ACT_FILL, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF);
		send_req(ACT_GET, 32'h0000_0000, 32'h0, 16'h0);
		send_req(ACT_TICK, 32'h0, 32'h0, 16'h0);
		send_req(ACT_TICK, 32'h0, 32'h0, 16'h0);
		send_req(ACT_GET, 32'h0000_0000, 32'h0, 16'h0);
		send_req(ACT_GET, 32'h7FFF_FFFF, 32'h0, 16'h0);

		// Capacity 2 with junk in the upper data bits, longest fill lifetime,
		// and writes to both unused indexes, which must change nothing.
		drain();
		write_reg(REG_CAPACITY, 16'hFFE2);
		write_reg(REG_DEFAULT_TTL, 16'hFFFF);
		write_reg(REG_SPARE_2, 16'h0001);
		write_reg(REG_SPARE_3, 16'hFFFF);
		// The fill makes the cache full; the put then evicts the oldest key.
		send_req(ACT_FILL, 32'h1, 32'h1, 16'h0);
		send_req(ACT_PUT, 32'h2, 32'h2, 16'h0);
		// Key 2 expires, yet the next put evicts key 1 because it is the
		// least recent: eviction does not look at expiry.
		send_req(ACT_TICK, 32'h0, 32'h0, 16'h0);
		send_req(ACT_TICK, 32'h0, 32'h0, 16'h0);
		send_req(ACT_PUT, 32'h3, 32'h3, 16'd10);

		// Grow the cache to six entries, then drop capacity to 0 (acting as
		// 1): each later insertion evicts exactly one entry and no more.
		drain();
		write_reg(REG_CAPACITY, 16'd16);
		for (int i = 0; i < 4; i++)
			send_req(ACT_FILL, 32'd10 + i, $urandom, 16'h0);
		drain();
		write_reg(REG_CAPACITY, 16'd0);
		send_req(ACT_PUT, 32'd14, 32'h5555_5555, 16'd1);
		send_req(ACT_PUT, 32'd15, 32'hAAAA_AAAA, 16'd1);

		// Random phases. Keys come mostly from a small per-phase pool so that
		// hits, expiries, replacements and evictions keep happening.
		for (int ph = 0; ph < PHASES; ph++) begin
			// Pausing here until all responses are in also keeps the
			// configuration writes away from any transaction in flight.
			drain();
			if (ph < 3) begin
				src_idle_pct = 23;
				snk_idle_pct = 61;
			end else if (ph < 6) begin
				src_idle_pct = 61;
				snk_idle_pct = 23;
			end else begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			wd = CFG_W'($urandom);
			wd[CAP_W-1:0] = CAP_W'(CAP_TAB[ph]);
			write_reg(REG_CAPACITY, wd);
			write_reg(REG_DEFAULT_TTL, CFG_W'(TTL_TAB[ph]));
			write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, CFG_W'($urandom));

			pool_size = $urandom_range(3, POOL_MAX);
			for (int i = 0; i < POOL_MAX; i++)
				key_pool[i] = $urandom;
			if ($urandom_range(0, 1)) begin
				key_pool[0] = 32'h8000_0000;
				key_pool[1] = 32'h7FFF_FFFF;
				key_pool[2] = 32'h0000_0000;
			end

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 40)
					act = ACT_GET;
				else if (pick < 65)
					act = ACT_PUT;
				else if (pick < 80)
					act = ACT_FILL;
				else
					act = ACT_TICK;
				if ($urandom_range(0, 99) < 85)
					k = key_pool[$urandom_range(0, pool_size - 1)];
				else
					k = $urandom;
				// Short lifetimes mostly, so entries expire within a phase.
				pick = $urandom_range(0, 9);
				if (pick < 7)
					t = TTL_W'($urandom_range(0, 6));
				else if (pick < 9)
					t = TTL_W'($urandom);
				else
					t = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
				send_req(act, k, $urandom, t);
			end
		end

		// Let everything come back, then keep the clock running to catch any
		// stray response the block might still produce.
		drain();
		repeat (8) @(posedge clk);

		$display("Covered %0d transactions over %0d cache settings, with idle gaps on both sides.",
			items_sent, PHASES + 4);
		$display("Responses checked included %0d hits, %0d expired gets and %0d evictions.",
			hit_count, expired_count, evict_count);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
